// ===== src/slbm_pkg.sv =====
// shared types, codes and reset constants for the serial loaded bank mapper
// no dependencies; imported by every module under src
package slbm_pkg;

  // access codes
  localparam logic [1:0] OP_CPU_READ  = 2'd0;
  localparam logic [1:0] OP_CPU_WRITE = 2'd1;
  localparam logic [1:0] OP_PPU_READ  = 2'd2;

  // fifth-write targets, from address bits 14:13
  localparam logic [1:0] TGT_CONTROL  = 2'd0;
  localparam logic [1:0] TGT_CHR_LOW  = 2'd1;
  localparam logic [1:0] TGT_CHR_HIGH = 2'd2;
  localparam logic [1:0] TGT_PRG      = 2'd3;

  // prg modes, from control bits 3:2
  localparam logic [1:0] PRG_MODE_FIXED_LOW  = 2'd2;
  localparam logic [1:0] PRG_MODE_FIXED_HIGH = 2'd3;

  // configuration register indexes
  localparam logic REG_PRG_BANK_COUNT = 1'b0;
  localparam logic REG_CHR_BANK_COUNT = 1'b1;

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int BANK_CNT_W  = 5;

  localparam logic [BANK_CNT_W-1:0] BANK_COUNT_RESET = 5'd16;
  localparam logic [4:0] SHIFT_RESET   = 5'h10;
  localparam logic [4:0] CONTROL_RESET = 5'h0C;
  localparam logic [4:0] CONTROL_SET   = 5'h0C;
  localparam logic [2:0] LOAD_WRITES   = 3'd5;
  localparam logic [17:0] PPU_OUT_OF_RANGE = 18'h000FF;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  data;
  } req_t;

  typedef struct packed {
    logic [17:0] mapped_offset;
    logic [1:0]  mirror_mode;
  } rsp_t;

  // bank registers as seen by the address translation
  typedef struct packed {
    logic [4:0] control;
    logic [1:0] mirror;
    logic [4:0] chr_low;
    logic [4:0] chr_high;
    logic [4:0] chr_full;
    logic [2:0] prg_full;
    logic [3:0] prg_low;
    logic [3:0] prg_high;
  } bank_state_t;

endpackage

// ===== src/serial_loaded_bank_mapper.sv =====
// top level of the serial loaded bank mapper: handshake stages, apb registers
// depends on slbm_pkg, slbm_loader, slbm_xlate
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+----------------------------------
//   req      | in        | req_valid/req_stall  | operation, address, data (req_t)
//   rsp      | out       | rsp_valid/rsp_stall  | mapped_offset, mirror_mode (rsp_t)
//   apb      | in/out    | psel/penable/pready  | bank count registers at 0x0, 0x4
//
// one access per cycle sustained while the response side does not stall; a request passes
// through the request register, then the response register, before it can transfer out
// the single-step update of the loader between those registers sets the rate
// synchronous active-high reset: loader shift 0x10 and write count 0, control 0x0c, counts 16
// a stalled response holds while one more request still transfers into the
// request register; req_stall rises only when both registers are full
module serial_loaded_bank_mapper
  import slbm_pkg::*;
#(
  parameter int CfgAddrW = CFG_ADDR_W
) (
  input  logic                  clk,
  input  logic                  rst,
  // request channel
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_t                  req,
  // response channel
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output rsp_t                  rsp,
  // apb configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CfgAddrW-1:0]   paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // configuration registers
  logic [BANK_CNT_W-1:0] prg_bank_count;
  logic [BANK_CNT_W-1:0] chr_bank_count;
  logic                  cfg_write;
  logic                  cfg_index;

  // request register
  logic stage_valid, stage_valid_next;
  req_t stage_item;
  logic req_xfer;
  logic advance;

  // response register
  logic rsp_valid_next;
  logic rsp_xfer;

  bank_state_t banks;
  logic [1:0]  mirror_next;
  logic [17:0] mapped_offset;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count <= BANK_COUNT_RESET;
      chr_bank_count <= BANK_COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PRG_BANK_COUNT: prg_bank_count <= pwdata[BANK_CNT_W-1:0];
        REG_CHR_BANK_COUNT: chr_bank_count <= pwdata[BANK_CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_PRG_BANK_COUNT: prdata = CFG_DATA_W'(prg_bank_count);
      REG_CHR_BANK_COUNT: prdata = CFG_DATA_W'(chr_bank_count);
      default:            prdata = '0;
    endcase
  end

  // the held request moves on whenever the response register is free or draining
  assign advance   = stage_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = stage_valid && !advance;
  assign req_xfer  = req_valid && !req_stall;
  assign rsp_xfer  = rsp_valid && !rsp_stall;

  always_comb begin
    stage_valid_next = stage_valid;
    if (req_xfer)     stage_valid_next = 1'b1;
    else if (advance) stage_valid_next = 1'b0;
    rsp_valid_next = rsp_valid;
    if (advance)       rsp_valid_next = 1'b1;
    else if (rsp_xfer) rsp_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      stage_valid <= stage_valid_next;
      rsp_valid   <= rsp_valid_next;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (req_xfer) stage_item <= req;
    if (advance) begin
      rsp.mapped_offset <= mapped_offset;
      rsp.mirror_mode   <= mirror_next;
    end
  end

  // the loader steps exactly once per request, as it leaves the request register; only cpu writes change bank state
  slbm_loader u_loader (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .item           (stage_item),
    .prg_bank_count (prg_bank_count),
    .banks          (banks),
    .mirror_next    (mirror_next)
  );

  slbm_xlate u_xlate (
    .item           (stage_item),
    .banks          (banks),
    .chr_bank_count (chr_bank_count),
    .mapped_offset  (mapped_offset)
  );

  // both registers full and the output stalled must push back on the request side
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && rsp_valid && rsp_stall) |-> req_stall)
    else $error("request accepted while both stages were full");

  // a held request with a free output always produces a response next cycle
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !rsp_stall) |=> rsp_valid)
    else $error("held request did not reach the response register");

  // an accepted request is held until it moves on
  a_capture: assert property (@(posedge clk) disable iff (rst)
    req_xfer |=> stage_valid)
    else $error("accepted request was lost");

endmodule

// ===== src/slbm_loader.sv =====
// serial loader and bank registers: shifts write data in, commits on the fifth write; bit 7 resets the shift
// depends on slbm_pkg
module slbm_loader
  import slbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  req_t                  item,
  input  logic [BANK_CNT_W-1:0] prg_bank_count,
  output bank_state_t           banks,
  output logic [1:0]            mirror_next
);

  logic [4:0]  serial_shift, serial_shift_next;
  logic [2:0]  write_count, write_count_next;
  bank_state_t banks_next;

  logic [4:0]            shifted;
  logic [2:0]            count_inc;
  logic [BANK_CNT_W-1:0] last_bank;

  always_comb begin
    banks_next        = banks;
    serial_shift_next = serial_shift;
    write_count_next  = write_count;
    shifted   = {item.data[0], serial_shift[4:1]};
    count_inc = write_count + 3'd1;
    last_bank = prg_bank_count - BANK_CNT_W'(1);
    if (step && item.operation == OP_CPU_WRITE) begin
      if (item.data[7]) begin
        serial_shift_next = SHIFT_RESET;
        write_count_next  = '0;
        banks_next.control = banks.control | CONTROL_SET;
      end else if (count_inc != LOAD_WRITES) begin
        serial_shift_next = shifted;
        write_count_next  = count_inc;
      end else begin
        serial_shift_next = '0;
        write_count_next  = '0;
        case (item.address[14:13])
          TGT_CONTROL: begin
            banks_next.control = shifted;
            banks_next.mirror  = shifted[1:0];
          end
          TGT_CHR_LOW: begin
            if (banks.control[4]) banks_next.chr_low = shifted;
            else                  banks_next.chr_full = {shifted[4:1], 1'b0};
          end
          TGT_CHR_HIGH: begin
            if (banks.control[4]) banks_next.chr_high = shifted;
          end
          TGT_PRG: begin
            case (banks.control[3:2])
              PRG_MODE_FIXED_LOW: begin
                banks_next.prg_low  = '0;
                banks_next.prg_high = shifted[3:0];
              end
              PRG_MODE_FIXED_HIGH: begin
                banks_next.prg_low  = shifted[3:0];
                banks_next.prg_high = last_bank[3:0];
              end
              default: begin
                banks_next.prg_full = shifted[3:1];
              end
            endcase
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign mirror_next = banks_next.mirror;

  always_ff @(posedge clk) begin
    if (rst) begin
      serial_shift <= SHIFT_RESET;
      write_count  <= '0;
      banks.control  <= CONTROL_RESET;
      banks.mirror   <= '0;
      banks.chr_low  <= '0;
      banks.chr_high <= '0;
      banks.chr_full <= '0;
      banks.prg_full <= '0;
      banks.prg_low  <= '0;
      banks.prg_high <= '0;
    end else begin
      serial_shift <= serial_shift_next;
      write_count  <= write_count_next;
      banks        <= banks_next;
    end
  end

endmodule

// ===== src/slbm_xlate.sv =====
// address translation of cpu and ppu reads into rom offsets
// depends on slbm_pkg
module slbm_xlate
  import slbm_pkg::*;
(
  input  req_t                  item,
  input  bank_state_t           banks,
  input  logic [BANK_CNT_W-1:0] chr_bank_count,
  output logic [17:0]           mapped_offset
);

  logic [17:0] cpu_offset;
  logic [17:0] ppu_offset;
  logic [3:0]  prg_bank;

  always_comb begin
    prg_bank = item.address[14] ? banks.prg_high : banks.prg_low;
    if (banks.control[3] && item.address[15]) begin
      cpu_offset = {prg_bank, item.address[13:0]};
    end else begin
      cpu_offset = {banks.prg_full, item.address[14:0]};
    end
  end

  always_comb begin
    if (chr_bank_count == '0) begin
      ppu_offset = {2'b00, item.address};
    end else if (banks.control[4]) begin
      // 4k mode: two independent windows, nothing above 0x1fff
      if (item.address[15:12] == 4'd0) begin
        ppu_offset = {1'b0, banks.chr_low, item.address[11:0]};
      end else if (item.address[15:13] == 3'd0) begin
        ppu_offset = {1'b0, banks.chr_high, item.address[11:0]};
      end else begin
        ppu_offset = PPU_OUT_OF_RANGE;
      end
    end else begin
      // 8k bank is always even, so the add reduces to a concatenation
      ppu_offset = {1'b0, banks.chr_full[4:1], item.address[12:0]};
    end
  end

  always_comb begin
    case (item.operation)
      OP_CPU_READ: mapped_offset = cpu_offset;
      OP_PPU_READ: mapped_offset = ppu_offset;
      default:     mapped_offset = '0;
    endcase
  end

endmodule
